// ===== hw/rtl/fpba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fit-policy allocator package
// Shared codes, field widths and the command format for the cell rows.
// ----------------------------------------------------------------------------
package fpba_pkg;

  localparam int REQ_W       = 17;     // request_size width
  localparam int PART_W      = 17;     // partition_words width
  localparam int RESET_WORDS = 65536;  // partition size after reset

  // Input actions.
  typedef enum logic [1:0] {
    ACT_ALLOC    = 2'd0,
    ACT_FREE     = 2'd1,
    ACT_COALESCE = 2'd2
  } action_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_MEMORY = 2'd1,
    ST_NO_OWNER  = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Fit policies.
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // Configuration register indexes.
  localparam logic [7:0] REG_FIT_POLICY = 8'd0;
  localparam logic [7:0] REG_PARTITION  = 8'd1;

  // Operations of a cell row.
  typedef enum logic [2:0] {
    OP_HOLD      = 3'd0,
    OP_SHL       = 3'd1,  // cells at or above lo take their upper neighbor
    OP_SHR       = 3'd2,  // cells above lo take their lower neighbor
    OP_SWAP_EVEN = 3'd3,  // compare-exchange pairs (0,1), (2,3), ...
    OP_SWAP_ODD  = 3'd4   // compare-exchange pairs (1,2), (3,4), ...
  } chain_op_t;

  typedef struct packed {
    chain_op_t op;
    logic      wen;
  } chain_cmd_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_A_FSCAN,
    S_A_FREM,
    S_A_USCAN,
    S_A_UINS,
    S_A_PSCAN,
    S_A_PINS,
    S_F_USCAN,
    S_F_UREM,
    S_F_FSCAN,
    S_F_FINS,
    S_C_SORT,
    S_C_MERGE,
    S_C_LAST,
    S_FINISH
  } state_t;

endpackage

// ===== hw/rtl/fit_policy_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fit-policy block allocator
// Free and used block tables in cell rows, driven by a scan sequencer.
// ----------------------------------------------------------------------------
// Every table search rotates the live part of a row past its head one entry
// per cycle, so the free and used table fills set how long an item takes.
// Throughput: one item is worked at a time; a waiting result delays only the
// finish of the next item. Reset: one free block spans the partition.
module fit_policy_block_allocator
  import fpba_pkg::*;
#(
  parameter int MAX_BLOCKS = 64,
  parameter int ADDR_BITS  = 16,
  parameter int OWNER_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  // Input items. s_tdata: action, owner_id, request_size (from bit 0 up).
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [((2+OWNER_BITS+REQ_W+7)/8)*8-1:0] s_tdata,
  // Result items. m_tdata: status, block_start, free_entries (from bit 0 up).
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [((2+ADDR_BITS+$clog2(MAX_BLOCKS+1)+7)/8)*8-1:0] m_tdata,
  // Register writes.
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [7:0]               cfg_index,
  input  logic [PART_W-1:0]        cfg_data
);

  localparam int AB    = ADDR_BITS;
  localparam int OB    = OWNER_BITS;
  localparam int IW    = $clog2(MAX_BLOCKS);
  localparam int CW    = $clog2(MAX_BLOCKS + 1);
  localparam int SW    = (AB + 1 > REQ_W) ? AB + 1 : REQ_W;
  localparam int FW    = 2 * AB;
  localparam int UW    = OB + 2 * AB;
  localparam int OUT_W = ((2 + AB + CW + 7) / 8) * 8;

  localparam logic [SW-1:0] CAP       = SW'(1) << AB;
  localparam logic [SW-1:0] RST_WORDS = (SW'(RESET_WORDS) > CAP) ? CAP : SW'(RESET_WORDS);
  localparam logic [SW-1:0] RST_LASTW = RST_WORDS - SW'(1);
  localparam logic [AB-1:0] RST_LAST  = RST_LASTW[AB-1:0];

  // Sequencer state.
  state_t         state, state_next;
  logic [1:0]     policy, policy_next;
  logic [CW-1:0]  fcnt, fcnt_next, ucnt, ucnt_next;
  logic [CW-1:0]  k, k_next, sel, sel_next, pos, pos_next, len, len_next;
  logic           found, found_next;
  logic [SW-1:0]  best, best_next;
  logic [AB-1:0]  blk_start, blk_start_next, blk_last, blk_last_next;
  logic [AB-1:0]  acc_start, acc_start_next, acc_last, acc_last_next;
  logic [AB-1:0]  res_start, res_start_next;
  status_t        res_status, res_status_next;
  logic [OB-1:0]  owner, owner_next;
  logic [REQ_W-1:0] req, req_next;
  logic           load_out;
  logic [OUT_W-1:0] out_data;

  // Row interfaces.
  chain_cmd_t     fcmd, ucmd;
  logic [IW-1:0]  flo, fwidx, ulo, uwidx;
  logic [FW-1:0]  fwdata, fhead;
  logic [UW-1:0]  uwdata, uhead;

  // Head fields and derived values.
  logic [AB-1:0]  fh_start, fh_last, uh_start;
  logic [OB-1:0]  uh_owner;
  logic [SW-1:0]  fh_span, req_w, frag_span, pw, words;
  logic [SW-1:0]  ulast_w, frag_start_w;
  logic [AB-1:0]  ulast, frag_start, part_last;
  logic [CW-1:0]  fcnt_m1, ucnt_m1, len_m1;
  logic [OB-1:0]  in_owner;
  logic [REQ_W-1:0] in_req;
  action_t        in_act;
  logic           s_acc, cfg_acc, take;

  assign fh_start = fhead[FW-1:AB];
  assign fh_last  = fhead[AB-1:0];
  assign uh_owner = uhead[UW-1 -: OB];
  assign uh_start = uhead[FW-1:AB];
  assign fh_span  = SW'(fh_last) - SW'(fh_start) + SW'(1);
  assign req_w    = SW'(req);

  // The allocated piece is carved from the low end of the chosen block.
  assign ulast_w      = SW'(blk_start) + req_w - SW'(1);
  assign ulast        = ulast_w[AB-1:0];
  assign frag_start_w = SW'(ulast) + SW'(1);
  assign frag_start   = frag_start_w[AB-1:0];
  assign frag_span    = SW'(blk_last) - SW'(ulast);

  assign fcnt_m1 = fcnt - CW'(1);
  assign ucnt_m1 = ucnt - CW'(1);
  assign len_m1  = len - CW'(1);

  // A partition size of zero counts as one word; sizes past the address
  // space are capped to it.
  assign pw        = SW'(cfg_data);
  assign words     = (pw == '0) ? SW'(1) : ((pw > CAP) ? CAP : pw);
  assign part_last = AB'(words - SW'(1));

  assign in_act   = action_t'(s_tdata[1:0]);
  assign in_owner = s_tdata[2 +: OB];
  assign in_req   = s_tdata[2+OB +: REQ_W];

  // Configuration goes first when both arrive in the same idle cycle.
  assign cfg_ready = (state == S_IDLE);
  assign s_tready  = (state == S_IDLE) && !cfg_valid;
  assign s_acc     = s_tvalid && s_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // The scan candidate test for allocation by policy.
  always_comb begin
    take = 1'b0;
    if (fh_span >= req_w) begin
      case (policy)
        POL_FIRST: take = !found;
        POL_BEST:  take = !found || (fh_span < best);
        POL_WORST: take = !found || (fh_span > best);
        default:   take = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      policy <= POL_FIRST;
      fcnt   <= CW'(1);
      ucnt   <= '0;
    end else begin
      state  <= state_next;
      policy <= policy_next;
      fcnt   <= fcnt_next;
      ucnt   <= ucnt_next;
    end
  end

  always_ff @(posedge clk) begin
    k          <= k_next;
    sel        <= sel_next;
    pos        <= pos_next;
    len        <= len_next;
    found      <= found_next;
    best       <= best_next;
    blk_start  <= blk_start_next;
    blk_last   <= blk_last_next;
    acc_start  <= acc_start_next;
    acc_last   <= acc_last_next;
    res_start  <= res_start_next;
    res_status <= res_status_next;
    owner      <= owner_next;
    req        <= req_next;
  end

  always_comb begin
    state_next      = state;
    policy_next     = policy;
    fcnt_next       = fcnt;
    ucnt_next       = ucnt;
    k_next          = k;
    sel_next        = sel;
    pos_next        = pos;
    len_next        = len;
    found_next      = found;
    best_next       = best;
    blk_start_next  = blk_start;
    blk_last_next   = blk_last;
    acc_start_next  = acc_start;
    acc_last_next   = acc_last;
    res_start_next  = res_start;
    res_status_next = res_status;
    owner_next      = owner;
    req_next        = req;
    load_out        = 1'b0;
    fcmd            = '{op: OP_HOLD, wen: 1'b0};
    ucmd            = '{op: OP_HOLD, wen: 1'b0};
    flo             = '0;
    fwidx           = '0;
    fwdata          = fhead;
    ulo             = '0;
    uwidx           = '0;
    uwdata          = uhead;

    case (state)
      S_IDLE: begin
        if (cfg_acc) begin
          if (cfg_index == REG_FIT_POLICY) begin
            policy_next = cfg_data[1:0];
          end else if (cfg_index == REG_PARTITION) begin
            fcnt_next = CW'(1);
            ucnt_next = '0;
            fcmd      = '{op: OP_HOLD, wen: 1'b1};
            fwidx     = '0;
            fwdata    = {{AB{1'b0}}, part_last};
          end
        end
        if (s_acc) begin
          owner_next      = in_owner;
          req_next        = in_req;
          k_next          = '0;
          found_next      = 1'b0;
          res_start_next  = '0;
          res_status_next = ST_OK;
          case (in_act)
            ACT_ALLOC: begin
              if (in_req == '0) begin
                res_status_next = ST_NO_MEMORY;
                state_next      = S_FINISH;
              end else if (ucnt >= CW'(MAX_BLOCKS)) begin
                res_status_next = ST_FULL;
                state_next      = S_FINISH;
              end else begin
                state_next = S_A_FSCAN;
              end
            end
            ACT_FREE: state_next = S_F_USCAN;
            ACT_COALESCE: begin
              state_next = (fcnt == '0) ? S_FINISH : S_C_SORT;
            end
            default: state_next = S_FINISH;
          endcase
        end
      end

      // Search the free row for the block to allocate from.
      S_A_FSCAN: begin
        if (k == fcnt) begin
          if (!found) begin
            res_status_next = ST_NO_MEMORY;
            state_next      = S_FINISH;
          end else begin
            state_next = S_A_FREM;
          end
        end else begin
          fcmd  = '{op: OP_SHL, wen: 1'b1};
          fwidx = fcnt_m1[IW-1:0];
          if (take) begin
            found_next     = 1'b1;
            sel_next       = k;
            best_next      = fh_span;
            blk_start_next = fh_start;
            blk_last_next  = fh_last;
          end
          k_next = k + CW'(1);
        end
      end

      S_A_FREM: begin
        fcmd       = '{op: OP_SHL, wen: 1'b0};
        flo        = sel[IW-1:0];
        fcnt_next  = fcnt_m1;
        k_next     = '0;
        found_next = 1'b0;
        pos_next   = ucnt;
        state_next = S_A_USCAN;
      end

      // Find the address-ordered slot in the used row.
      S_A_USCAN: begin
        if (k == ucnt) begin
          state_next = S_A_UINS;
        end else begin
          ucmd  = '{op: OP_SHL, wen: 1'b1};
          uwidx = ucnt_m1[IW-1:0];
          if (!found && (uh_start > blk_start)) begin
            found_next = 1'b1;
            pos_next   = k;
          end
          k_next = k + CW'(1);
        end
      end

      S_A_UINS: begin
        ucmd           = '{op: OP_SHR, wen: 1'b1};
        ulo            = pos[IW-1:0];
        uwidx          = pos[IW-1:0];
        uwdata         = {owner, blk_start, ulast};
        ucnt_next      = ucnt + CW'(1);
        res_start_next = blk_start;
        k_next         = '0;
        found_next     = 1'b0;
        pos_next       = fcnt;
        if (ulast < blk_last) begin
          state_next = (policy == POL_FIRST) ? S_A_PINS : S_A_PSCAN;
        end else begin
          state_next = S_FINISH;
        end
      end

      // Place the remainder: best fit before the first larger block,
      // worst fit before the first smaller one.
      S_A_PSCAN: begin
        if (k == fcnt) begin
          state_next = S_A_PINS;
        end else begin
          fcmd  = '{op: OP_SHL, wen: 1'b1};
          fwidx = fcnt_m1[IW-1:0];
          if (!found && (policy == POL_BEST ? (fh_span > frag_span)
                                            : (fh_span < frag_span))) begin
            found_next = 1'b1;
            pos_next   = k;
          end
          k_next = k + CW'(1);
        end
      end

      S_A_PINS: begin
        fcmd       = '{op: OP_SHR, wen: 1'b1};
        flo        = pos[IW-1:0];
        fwidx      = pos[IW-1:0];
        fwdata     = {frag_start, blk_last};
        fcnt_next  = fcnt + CW'(1);
        state_next = S_FINISH;
      end

      // Find the first used block of the owner.
      S_F_USCAN: begin
        if (k == ucnt) begin
          if (!found) begin
            res_status_next = ST_NO_OWNER;
            state_next      = S_FINISH;
          end else if (fcnt >= CW'(MAX_BLOCKS)) begin
            res_status_next = ST_FULL;
            state_next      = S_FINISH;
          end else begin
            state_next = S_F_UREM;
          end
        end else begin
          ucmd  = '{op: OP_SHL, wen: 1'b1};
          uwidx = ucnt_m1[IW-1:0];
          if (!found && (uh_owner == owner)) begin
            found_next     = 1'b1;
            sel_next       = k;
            blk_start_next = uh_start;
            blk_last_next  = uhead[AB-1:0];
          end
          k_next = k + CW'(1);
        end
      end

      S_F_UREM: begin
        ucmd       = '{op: OP_SHL, wen: 1'b0};
        ulo        = sel[IW-1:0];
        ucnt_next  = ucnt_m1;
        k_next     = '0;
        found_next = 1'b0;
        pos_next   = fcnt;
        state_next = S_F_FSCAN;
      end

      S_F_FSCAN: begin
        if (k == fcnt) begin
          state_next = S_F_FINS;
        end else begin
          fcmd  = '{op: OP_SHL, wen: 1'b1};
          fwidx = fcnt_m1[IW-1:0];
          if (!found && (fh_start > blk_start)) begin
            found_next = 1'b1;
            pos_next   = k;
          end
          k_next = k + CW'(1);
        end
      end

      S_F_FINS: begin
        fcmd           = '{op: OP_SHR, wen: 1'b1};
        flo            = pos[IW-1:0];
        fwidx          = pos[IW-1:0];
        fwdata         = {blk_start, blk_last};
        fcnt_next      = fcnt + CW'(1);
        res_start_next = blk_start;
        state_next     = S_FINISH;
      end

      // Odd-even transposition sort by start address, one phase a cycle.
      S_C_SORT: begin
        if (k == fcnt) begin
          k_next     = '0;
          len_next   = fcnt;
          state_next = S_C_MERGE;
        end else begin
          fcmd   = '{op: (k[0] ? OP_SWAP_ODD : OP_SWAP_EVEN), wen: 1'b0};
          k_next = k + CW'(1);
        end
      end

      // Pop each block off the head; touching blocks grow the accumulator,
      // a gap pushes the accumulator to the back of the live entries.
      S_C_MERGE: begin
        if (k == fcnt) begin
          state_next = S_C_LAST;
        end else begin
          fcmd   = '{op: OP_SHL, wen: 1'b0};
          k_next = k + CW'(1);
          if (k == '0) begin
            acc_start_next = fh_start;
            acc_last_next  = fh_last;
            len_next       = len_m1;
          end else if (SW'(acc_last) + SW'(1) == SW'(fh_start)) begin
            acc_last_next = fh_last;
            len_next      = len_m1;
          end else begin
            fcmd           = '{op: OP_SHL, wen: 1'b1};
            fwidx          = len_m1[IW-1:0];
            fwdata         = {acc_start, acc_last};
            acc_start_next = fh_start;
            acc_last_next  = fh_last;
          end
        end
      end

      S_C_LAST: begin
        fcmd       = '{op: OP_HOLD, wen: 1'b1};
        fwidx      = len[IW-1:0];
        fwdata     = {acc_start, acc_last};
        fcnt_next  = len + CW'(1);
        state_next = S_FINISH;
      end

      S_FINISH: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase

    // Reset loads the single free block covering the partition.
    if (rst) begin
      fcmd   = '{op: OP_HOLD, wen: 1'b1};
      fwidx  = '0;
      fwdata = {{AB{1'b0}}, RST_LAST};
    end
  end

  fpba_chain #(
    .DEPTH(MAX_BLOCKS), .W(FW), .KEY_LSB(AB), .KEY_W(AB)
  ) u_free (
    .clk(clk), .cmd(fcmd), .lo(flo), .widx(fwidx), .wdata(fwdata),
    .cnt(fcnt), .head(fhead)
  );

  fpba_chain #(
    .DEPTH(MAX_BLOCKS), .W(UW), .KEY_LSB(AB), .KEY_W(AB)
  ) u_used (
    .clk(clk), .cmd(ucmd), .lo(ulo), .widx(uwidx), .wdata(uwdata),
    .cnt(ucnt), .head(uhead)
  );

  // Output register: holds a finished result while the next item is taken.
  always_comb begin
    out_data            = '0;
    out_data[1:0]       = res_status;
    out_data[2 +: AB]   = res_start;
    out_data[2+AB +: CW] = fcnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) m_tdata <= out_data;
  end

endmodule

// ===== hw/rtl/fpba_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator table cell
// Holds one table entry and trades it with its neighbors on command.
// ----------------------------------------------------------------------------
module fpba_cell
  import fpba_pkg::*;
#(
  parameter int W       = 32,
  parameter int KEY_LSB = 16,
  parameter int KEY_W   = 16,
  parameter int IW      = 6,
  parameter int CW      = 7,
  parameter int IDX     = 0
) (
  input  logic          clk,
  input  chain_cmd_t    cmd,
  input  logic [IW-1:0] lo,
  input  logic [IW-1:0] widx,
  input  logic [W-1:0]  wdata,
  input  logic [CW-1:0] cnt,
  input  logic [W-1:0]  prev_data,
  input  logic [W-1:0]  next_data,
  output logic [W-1:0]  data
);

  localparam bit IS_EVEN = ((IDX % 2) == 0);

  logic [W-1:0]     data_next;
  logic [KEY_W-1:0] key_cur, key_prv, key_nxt;
  logic             lower;

  assign key_cur = data[KEY_LSB +: KEY_W];
  assign key_prv = prev_data[KEY_LSB +: KEY_W];
  assign key_nxt = next_data[KEY_LSB +: KEY_W];
  assign lower   = ((cmd.op == OP_SWAP_EVEN) == IS_EVEN);

  always_comb begin
    data_next = data;
    case (cmd.op)
      OP_HOLD: data_next = data;
      OP_SHL: begin
        if (IW'(IDX) >= lo) data_next = next_data;
      end
      OP_SHR: begin
        if (IW'(IDX) > lo) data_next = prev_data;
      end
      OP_SWAP_EVEN, OP_SWAP_ODD: begin
        if (lower) begin
          if ((CW'(IDX + 1) < cnt) && (key_cur > key_nxt)) data_next = next_data;
        end else begin
          if ((IDX >= 1) && (CW'(IDX) < cnt) && (key_prv > key_cur)) data_next = prev_data;
        end
      end
      default: data_next = data;
    endcase
    if (cmd.wen && (widx == IW'(IDX))) data_next = wdata;
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ===== hw/rtl/fpba_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator table row
// A row of cells holding one table; entry 0 is visible at the head.
// ----------------------------------------------------------------------------
module fpba_chain
  import fpba_pkg::*;
#(
  parameter int DEPTH   = 64,
  parameter int W       = 32,
  parameter int KEY_LSB = 16,
  parameter int KEY_W   = 16
) (
  input  logic                       clk,
  input  chain_cmd_t                 cmd,
  input  logic [$clog2(DEPTH)-1:0]   lo,
  input  logic [$clog2(DEPTH)-1:0]   widx,
  input  logic [W-1:0]               wdata,
  input  logic [$clog2(DEPTH+1)-1:0] cnt,
  output logic [W-1:0]               head
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0] row [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [W-1:0] prv, nxt;
    if (i == 0) begin : g_first
      assign prv = '0;
    end else begin : g_mid_lo
      assign prv = row[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign nxt = '0;
    end else begin : g_mid_hi
      assign nxt = row[i+1];
    end
    fpba_cell #(
      .W(W), .KEY_LSB(KEY_LSB), .KEY_W(KEY_W), .IW(IW), .CW(CW), .IDX(i)
    ) u_cell (
      .clk(clk), .cmd(cmd), .lo(lo), .widx(widx), .wdata(wdata), .cnt(cnt),
      .prev_data(prv), .next_data(nxt), .data(row[i])
    );
  end

  assign head = row[0];

endmodule

// ===== hw/rtl/fpba_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator port checker
// Watches the allocator ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module fpba_chk
  import fpba_pkg::*;
#(
  parameter int MAX_BLOCKS = 64,
  parameter int ADDR_BITS  = 16
) (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [((2+ADDR_BITS+$clog2(MAX_BLOCKS+1)+7)/8)*8-1:0] m_tdata,
  input logic cfg_valid,
  input logic cfg_ready
);

  localparam int CW = $clog2(MAX_BLOCKS + 1);

  logic [1:0]           st;
  logic [ADDR_BITS-1:0] start;
  logic [CW-1:0]        fe;

  assign st    = m_tdata[1:0];
  assign start = m_tdata[2 +: ADDR_BITS];
  assign fe    = m_tdata[2+ADDR_BITS +: CW];

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready && !cfg_ready)
    else $error("new item or write taken while an item is in work");

  a_cfg_first: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |-> !s_tready)
    else $error("item taken in the same cycle as a register write");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> fe <= CW'(MAX_BLOCKS))
    else $error("free entry count beyond table size");

  a_err_start: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (st != ST_OK) |-> start == '0)
    else $error("error result carries an address");

endmodule

bind fit_policy_block_allocator fpba_chk #(
  .MAX_BLOCKS(MAX_BLOCKS), .ADDR_BITS(ADDR_BITS)
) u_fpba_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
  .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fit-policy block allocator testbench
// Drives allocate, free and coalesce items through the stream port, mirrors
// the free and used block tables in a local allocator model, and compares
// every result item field by field against the predicted status, block start
// and free entry count. Runs a directed table first and then random phases
// under several fit policies, partition sizes and idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import fpba_pkg::*;

  localparam int NBLK      = 64;
  localparam int ADDR_CAP  = 65536;
  localparam int SETTLE    = 300;      // cycles the block may still be busy
  localparam int LIMIT     = 2000000;  // cycle limit for the whole run
  localparam int PHASE_N   = 190;      // random items per phase

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // s_tdata: action [1:0], owner_id [9:2], request_size [26:10].
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // m_tdata: status [1:0], block_start [17:2], free_entries [24:18].
  logic [31:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;

  always #4 clk = ~clk;

  fit_policy_block_allocator DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // One expected result item.
  typedef struct {
    status_t st;
    int      start;
    int      fe;
  } alloc_result_t;

  // One row of the directed part. Rows with typed set carry an expectation
  // that can be read off at a glance; the rest are left to the model.
  typedef struct {
    logic [1:0]  act;
    logic [7:0]  own;
    logic [16:0] req;
    bit          typed;
    status_t     st;
    int          start;
    int          fe;
  } dir_row_t;

  alloc_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // Local copy of the allocator state. Free blocks are kept in table order,
  // used blocks sorted by start address.
  int          fr_start[NBLK];
  int          fr_last[NBLK];
  int          fr_cnt;
  int          us_start[NBLK];
  int          us_last[NBLK];
  logic [7:0]  us_owner[NBLK];
  int          us_cnt;
  logic [1:0]  policy;
  int          part_words;

  task automatic report_mismatch(string field, int got, int want);
    $display("ERROR cycle %0d: %s got %0d expected %0d", cycles, field, got, want);
    errors++;
  endtask

  function automatic void set_partition(int words);
    if (words == 0) words = 1;
    if (words > ADDR_CAP) words = ADDR_CAP;
    part_words = words;
    fr_start[0] = 0;
    fr_last[0] = words - 1;
    fr_cnt = 1;
    us_cnt = 0;
  endfunction

  function automatic void free_insert(int pos, int s, int l);
    for (int k = fr_cnt; k > pos; k--) begin
      fr_start[k] = fr_start[k-1];
      fr_last[k] = fr_last[k-1];
    end
    fr_start[pos] = s;
    fr_last[pos] = l;
    fr_cnt++;
  endfunction

  function automatic void free_remove(int pos);
    for (int k = pos; k < fr_cnt - 1; k++) begin
      fr_start[k] = fr_start[k+1];
      fr_last[k] = fr_last[k+1];
    end
    fr_cnt--;
  endfunction

  // Carves a block by the current policy; returns the status and the start.
  function automatic status_t carve_block(logic [7:0] own, int req, output int where);
    int sel, best, sz, bs, bl, pos, ulast, fs;
    sel = -1;
    best = 0;
    where = 0;
    if (req == 0) return ST_NO_MEMORY;
    if (us_cnt >= NBLK) return ST_FULL;
    for (int i = 0; i < fr_cnt; i++) begin
      sz = fr_last[i] - fr_start[i] + 1;
      if (sz < req) continue;
      if (policy == POL_FIRST) begin
        sel = i;
        break;
      end
      if (policy == POL_BEST && (sel < 0 || sz < best)) begin
        sel = i;
        best = sz;
      end
      if (policy == POL_WORST && (sel < 0 || sz > best)) begin
        sel = i;
        best = sz;
      end
    end
    if (sel < 0) return ST_NO_MEMORY;
    bs = fr_start[sel];
    bl = fr_last[sel];
    free_remove(sel);
    ulast = bs + req - 1;
    pos = 0;
    while (pos < us_cnt && us_start[pos] <= bs) pos++;
    for (int k = us_cnt; k > pos; k--) begin
      us_start[k] = us_start[k-1];
      us_last[k] = us_last[k-1];
      us_owner[k] = us_owner[k-1];
    end
    us_start[pos] = bs;
    us_last[pos] = ulast;
    us_owner[pos] = own;
    us_cnt++;
    where = bs;
    // The remainder goes back by policy: appended, ahead of the first larger
    // block, or ahead of the first smaller block.
    if (ulast < bl) begin
      fs = bl - ulast;
      pos = 0;
      if (policy == POL_FIRST) pos = fr_cnt;
      else if (policy == POL_BEST)
        while (pos < fr_cnt && fr_last[pos] - fr_start[pos] + 1 <= fs) pos++;
      else
        while (pos < fr_cnt && fr_last[pos] - fr_start[pos] + 1 >= fs) pos++;
      free_insert(pos, ulast + 1, bl);
    end
    return ST_OK;
  endfunction

  function automatic alloc_result_t predict_result(logic [1:0] act, logic [7:0] own,
                                                   logic [16:0] req);
    alloc_result_t r;
    int i, pos, s, l, n, ts, tl, w;
    r.st = ST_OK;
    r.start = 0;
    if (act == ACT_ALLOC) begin
      r.st = carve_block(own, int'(req), w);
      if (r.st == ST_OK) r.start = w;
    end else if (act == ACT_FREE) begin
      i = 0;
      while (i < us_cnt && us_owner[i] != own) i++;
      if (i == us_cnt) r.st = ST_NO_OWNER;
      else if (fr_cnt >= NBLK) r.st = ST_FULL;
      else begin
        s = us_start[i];
        l = us_last[i];
        for (int k = i; k < us_cnt - 1; k++) begin
          us_start[k] = us_start[k+1];
          us_last[k] = us_last[k+1];
          us_owner[k] = us_owner[k+1];
        end
        us_cnt--;
        pos = 0;
        while (pos < fr_cnt && fr_start[pos] <= s) pos++;
        free_insert(pos, s, l);
        r.start = s;
      end
    end else if (act == ACT_COALESCE) begin
      // Insertion sort by start address, then merge touching neighbors.
      for (int a = 1; a < fr_cnt; a++) begin
        ts = fr_start[a];
        tl = fr_last[a];
        i = a;
        while (i > 0 && fr_start[i-1] > ts) begin
          fr_start[i] = fr_start[i-1];
          fr_last[i] = fr_last[i-1];
          i--;
        end
        fr_start[i] = ts;
        fr_last[i] = tl;
      end
      if (fr_cnt > 0) begin
        n = 1;
        for (int a = 1; a < fr_cnt; a++) begin
          if (fr_last[n-1] + 1 == fr_start[a]) fr_last[n-1] = fr_last[a];
          else begin
            fr_start[n] = fr_start[a];
            fr_last[n] = fr_last[a];
            n++;
          end
        end
        fr_cnt = n;
      end
    end
    r.start = r.start & 16'hFFFF;
    r.fe = fr_cnt;
    return r;
  endfunction

  // Sends one item. The valid stays high from item to item unless a random
  // gap lowers it, so it is never lowered and raised in the same step.
  task automatic send_item(logic [1:0] act, logic [7:0] own, logic [16:0] req,
                           bit typed = 0, alloc_result_t typed_res = '{ST_OK, 0, 0});
    alloc_result_t r;
    @(negedge clk);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      while ($urandom_range(99) < tx_idle_pct) @(negedge clk);
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, req, own, act};
    do @(posedge clk); while (!s_tready);
    r = predict_result(act, own, req);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Register writes happen only with nothing in flight and the block settled.
  task automatic write_reg(logic [7:0] idx, logic [16:0] val);
    drain_results();
    repeat (SETTLE) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_FIT_POLICY) policy = val[1:0];
    else if (idx == REG_PARTITION) set_partition(int'(val));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random item: mostly allocations and frees over a small owner pool, so
  // that frees find owners and the tables fill and fragment.
  task automatic send_random();
    int sel, rq;
    logic [7:0] own;
    own = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
    sel = $urandom_range(99);
    if (sel < 50) begin
      sel = $urandom_range(99);
      if (sel < 3) rq = 0;
      else if (sel < 8) rq = $urandom_range(131071);
      else if (sel < 16) rq = $urandom_range(part_words);
      else rq = $urandom_range((part_words / 16 > 1) ? part_words / 16 : 1, 1);
      send_item(ACT_ALLOC, own, 17'(rq));
    end else if (sel < 85) send_item(ACT_FREE, own, 17'($urandom_range(131071)));
    else if (sel < 95) send_item(ACT_COALESCE, own, 17'($urandom_range(131071)));
    else send_item(2'd3, own, 17'($urandom_range(131071)));
  endtask

  // Result checker: each accepted result item against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) report_mismatch("unexpected result", 1, 0);
      else begin
        alloc_result_t e;
        e = pending_results.pop_front();
        if (m_tdata[1:0] != e.st)
          report_mismatch("status", int'(m_tdata[1:0]), int'(e.st));
        if (m_tdata[17:2] != e.start)
          report_mismatch("block_start", int'(m_tdata[17:2]), e.start);
        if (m_tdata[24:18] != e.fe)
          report_mismatch("free_entries", int'(m_tdata[24:18]), e.fe);
      end
    end
  end

  // Receiver stalls follow the current phase.
  always @(negedge clk) m_tready <= ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("fit_policy_block_allocator: mismatch");
      $finish;
    end
  end

  dir_row_t dir_rows[22] = '{
    // Zero and oversized requests after reset, whole partition in one block.
    '{ACT_ALLOC, 8'd0,   17'd0,      1, ST_NO_MEMORY, 0,   1},
    '{ACT_ALLOC, 8'd255, 17'h1FFFF,  1, ST_NO_MEMORY, 0,   1},
    '{ACT_ALLOC, 8'd7,   17'd65536,  1, ST_OK,        0,   0},
    '{ACT_ALLOC, 8'd8,   17'd1,      1, ST_NO_MEMORY, 0,   0},
    '{ACT_FREE,  8'd9,   17'd0,      1, ST_NO_OWNER,  0,   0},
    // Coalesce with an empty free table.
    '{ACT_COALESCE, 8'd0, 17'd0,     1, ST_OK,        0,   0},
    '{ACT_FREE,  8'd7,   17'd5,      1, ST_OK,        0,   1},
    // Undefined action does nothing.
    '{2'd3,      8'hAA,  17'h15555,  1, ST_OK,        0,   1},
    '{ACT_ALLOC, 8'd0,   17'd100,    1, ST_OK,        0,   1},
    '{ACT_ALLOC, 8'd1,   17'd50,     1, ST_OK,        100, 1},
    '{ACT_ALLOC, 8'd2,   17'd1,      1, ST_OK,        150, 1},
    '{ACT_FREE,  8'd0,   17'h0AAAA,  1, ST_OK,        0,   2},
    '{ACT_FREE,  8'd1,   17'd0,      1, ST_OK,        100, 3},
    '{ACT_COALESCE, 8'd3, 17'd0,     1, ST_OK,        0,   2},
    '{ACT_ALLOC, 8'd3,   17'd65536,  1, ST_NO_MEMORY, 0,   2},
    // The rest are left to the model.
    '{ACT_ALLOC, 8'd255, 17'd150,    0, ST_OK,        0,   0},
    '{ACT_ALLOC, 8'd4,   17'h0AAAA,  0, ST_OK,        0,   0},
    '{ACT_ALLOC, 8'd5,   17'h05555,  0, ST_OK,        0,   0},
    '{ACT_FREE,  8'd2,   17'd0,      0, ST_OK,        0,   0},
    '{ACT_FREE,  8'd4,   17'd0,      0, ST_OK,        0,   0},
    '{ACT_COALESCE, 8'd0, 17'd0,     0, ST_OK,        0,   0},
    '{ACT_FREE,  8'd255, 17'd0,      0, ST_OK,        0,   0}
  };

  initial begin
    alloc_result_t tr;
    policy = POL_FIRST;
    set_partition(RESET_WORDS);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      tr = '{dir_rows[i].st, dir_rows[i].start, dir_rows[i].fe};
      send_item(dir_rows[i].act, dir_rows[i].own, dir_rows[i].req, dir_rows[i].typed, tr);
    end

    // Fill the used table with one-word blocks until it reports full, then
    // free them all until the free table is full.
    write_reg(REG_FIT_POLICY, 17'h1FFFC);
    write_reg(REG_PARTITION, 17'd128);
    for (int i = 1; i <= NBLK + 1; i++) send_item(ACT_ALLOC, 8'(i), 17'd1);
    for (int i = 1; i <= NBLK; i++) send_item(ACT_FREE, 8'(i), 17'd0);
    // An index beyond the register list must be ignored.
    write_reg(8'hFF, 17'h1FFFF);

    // Random phases: policy, partition and idling change from phase to phase.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
        1: begin tx_idle_pct = 57; rx_idle_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_idle_pct = 57; end
        default: begin tx_idle_pct = 35; rx_idle_pct = 35; end
      endcase
      case (ph)
        0: begin write_reg(REG_FIT_POLICY, 17'd1); write_reg(REG_PARTITION, 17'd0); end
        1: begin write_reg(REG_FIT_POLICY, 17'd2); write_reg(REG_PARTITION, 17'h1FFFF); end
        2: begin write_reg(REG_FIT_POLICY, 17'd0); write_reg(REG_PARTITION, 17'd200); end
        3: begin write_reg(REG_FIT_POLICY, 17'd1); write_reg(REG_PARTITION, 17'd1000); end
        4: begin write_reg(REG_FIT_POLICY, 17'd2); write_reg(REG_PARTITION, 17'd512); end
        5: begin write_reg(REG_FIT_POLICY, 17'd3); write_reg(REG_PARTITION, 17'd300); end
        6: begin
          write_reg(REG_FIT_POLICY, 17'd0);
          write_reg(REG_PARTITION, 17'($urandom_range(4096, 64)));
        end
        default: begin
          write_reg(REG_FIT_POLICY, 17'd1);
          write_reg(REG_PARTITION, 17'd65536);
        end
      endcase
      for (int n = 0; n < PHASE_N; n++) begin
        // Halfway through one phase the sender waits for every result.
        if (ph == 3 && n == PHASE_N / 2) drain_results();
        send_random();
      end
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) $display("fit_policy_block_allocator: match");
    else $display("fit_policy_block_allocator: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/fpba_pkg.sv
hw/rtl/fpba_cell.sv
hw/rtl/fpba_chain.sv
hw/rtl/fit_policy_block_allocator.sv
hw/rtl/fpba_chk.sv
tb/tb_top.sv
